/* rtl/core/rau_pkg.sv */
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS);

  localparam logic [2:0] CMD_NORM  = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_SUB   = 3'd2;
  localparam logic [2:0] CMD_MUL   = 3'd3;
  localparam logic [2:0] CMD_DIV   = 3'd4;
  localparam logic [2:0] CMD_NEG   = 3'd5;
  localparam logic [2:0] CMD_RECIP = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [2:0]                  cmd;
    logic signed [WORD_BITS-1:0] a_num;
    logic signed [WORD_BITS-1:0] a_den;
    logic signed [WORD_BITS-1:0] b_num;
    logic [WORD_BITS-2:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_num;
    logic signed [WORD_BITS-1:0] res_den;
    logic [1:0]                  status;
  } rau_out_t;

  // magnitude of a signed word; the most negative value maps to 2^(W-1)
  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] x);
    mag = x[WORD_BITS-1] ? (~x + WORD_BITS'(1)) : x;
  endfunction

endpackage

/* rtl/core/rational_arithmetic_unit.sv */
// Rational arithmetic unit: normalize, add, subtract, multiply, divide,
// negate and reciprocal on fractions of 32-bit signed words.
// Input channel op_valid / op_ready / op carries one command and operands a
// and b; output channel res_valid / res_ready / res returns one item per
// command: reduced numerator, positive denominator and a status code
// (ok, overflow, division by zero). On any error the result is a unchanged.
// One item is worked on at a time; op_ready is high only while idle.
// Early errors and the unused command go straight to the result. The work is
// done by one shared binary-GCD stepper (one shift or subtract per cycle), one
// shared restoring divider (two quotients per GCD) and one shared 33x33
// multiplier. Add/subtract and divide run GCD+divide twice and take two or
// three products; multiply runs one GCD and two products; the unary commands
// one GCD.
// The result sits in an output register and the unit goes idle at once. If
// the receiver stalls, the next finished result holds in S_FIN with op_ready
// low until the output register frees up.
// Reset (synchronous, active high) returns to idle and drops any result.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     op_valid,
  output logic     op_ready,
  input  rau_in_t  op,
  output logic     res_valid,
  input  logic     res_ready,
  output rau_out_t res
);

  localparam int W = WORD_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RLOAD, S_GCD, S_DLOAD, S_DIV, S_POST,
    S_MUL, S_MCHK, S_SUM, S_FIN
  } state_t;

  typedef enum logic [1:0] {PH_RED, PH_ADD, PH_DIV} phase_t;

  state_t                 state;
  phase_t                 phase;
  rau_in_t                item;
  logic signed [W-1:0]    wn, wd;      // fraction to reduce
  logic [W-1:0]           d0, d1;      // GCD operands, kept for the divides
  logic [W-1:0]           u, v, g;
  logic [CNT_W-1:0]       k, cnt;
  logic [W-1:0]           dq, drem;
  logic                   didx;
  logic [W-1:0]           q0, q1;
  logic                   sn, sd;
  logic signed [W:0]      mb_n;
  logic [W-1:0]           mb_d;
  logic [1:0]             mstep;
  logic signed [2*W+1:0]  prod;
  logic signed [W-1:0]    t0, t1, t2;
  logic [1:0]             st;
  logic signed [W-1:0]    rnum, rden;

  // divider step
  logic [W:0]  dtry, dsub;
  logic        dge;
  logic [W-1:0] dq_next, drem_next;

  assign dtry      = {drem, dq[W-1]};
  assign dsub      = dtry - {1'b0, g};
  assign dge       = dtry >= {1'b0, g};
  assign drem_next = dge ? dsub[W-1:0] : dtry[W-1:0];
  assign dq_next   = {dq[W-2:0], dge};

  // multiplier operands
  logic              is_add;
  logic signed [W:0] ua_s, an_s, ad_s, bx_s, q0_s, opa, opb;
  logic signed [W-1:0] bx;

  assign is_add = (item.cmd == CMD_ADD) || (item.cmd == CMD_SUB);
  assign bx     = (item.cmd == CMD_SUB) ? -item.b_num : item.b_num;
  assign ua_s   = item.a_den[W-1] ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
  assign q0_s   = item.b_num[W-1] ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
  assign an_s   = {item.a_num[W-1], item.a_num};
  assign ad_s   = {item.a_den[W-1], item.a_den};
  assign bx_s   = {bx[W-1], bx};

  always_comb begin
    opa = an_s;
    opb = mb_n;
    if (is_add) begin
      case (mstep)
        2'd0: begin
          opa = ua_s;
          opb = $signed({2'b00, item.b_den});
        end
        2'd1: begin
          opa = an_s;
          opb = $signed({1'b0, q1});
        end
        default: begin
          opa = bx_s;
          opb = ua_s;
        end
      endcase
    end else begin
      case (mstep)
        2'd0: begin
          opa = an_s;
          opb = mb_n;
        end
        default: begin
          opa = ad_s;
          opb = $signed({1'b0, mb_d});
        end
      endcase
    end
  end

  logic prod_fits, last_step;
  assign prod_fits = (&prod[2*W+1:W-1]) | ~(|prod[2*W+1:W-1]);
  assign last_step = is_add ? (mstep == 2'd2) : (mstep == 2'd1);

  // sum for add/subtract and result of a reduction
  logic signed [W:0] sum;
  logic              rneg, rovf;
  assign sum  = {t1[W-1], t1} + {t2[W-1], t2};
  assign rneg = sn ^ sd;
  assign rovf = q1[W-1] | (rneg ? (q0[W-1] & (|q0[W-2:0])) : q0[W-1]);

  logic fin_load;
  assign fin_load = (state == S_FIN) && (!res_valid || res_ready);
  assign op_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // drop the taken result unless a new one is loaded this cycle
      if (res_valid && res_ready && !fin_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (op_valid) begin
            item  <= op;
            st    <= ST_OK;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          case (item.cmd)
            CMD_NORM: begin
              if (item.a_den == '0) begin
                st    <= ST_DIV0;
                state <= S_FIN;
              end else begin
                wn    <= item.a_num;
                wd    <= item.a_den;
                state <= S_RLOAD;
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (item.a_den == '0 || item.b_den == '0) begin
                st    <= ST_DIV0;
                state <= S_FIN;
              end else if (item.cmd == CMD_MUL) begin
                mb_n  <= {item.b_num[W-1], item.b_num};
                mb_d  <= {1'b0, item.b_den};
                mstep <= 2'd0;
                state <= S_MUL;
              end else if (item.cmd == CMD_DIV) begin
                if (item.b_num == '0) begin
                  st    <= ST_DIV0;
                  state <= S_FIN;
                end else begin
                  d0    <= {1'b0, item.b_den};
                  d1    <= mag(item.b_num);
                  u     <= {1'b0, item.b_den};
                  v     <= mag(item.b_num);
                  k     <= '0;
                  phase <= PH_DIV;
                  state <= S_GCD;
                end
              end else if (item.cmd == CMD_SUB && item.b_num == {1'b1, {(W-1){1'b0}}}) begin
                st    <= ST_OVF;
                state <= S_FIN;
              end else begin
                d0    <= mag(item.a_den);
                d1    <= {1'b0, item.b_den};
                u     <= mag(item.a_den);
                v     <= {1'b0, item.b_den};
                k     <= '0;
                phase <= PH_ADD;
                state <= S_GCD;
              end
            end
            CMD_NEG: begin
              if (item.a_den == '0) begin
                st    <= ST_DIV0;
                state <= S_FIN;
              end else if (item.a_num == {1'b1, {(W-1){1'b0}}}) begin
                st    <= ST_OVF;
                state <= S_FIN;
              end else begin
                wn    <= -item.a_num;
                wd    <= item.a_den;
                state <= S_RLOAD;
              end
            end
            CMD_RECIP: begin
              if (item.a_num == '0) begin
                st    <= ST_DIV0;
                state <= S_FIN;
              end else begin
                wn    <= item.a_den;
                wd    <= item.a_num;
                state <= S_RLOAD;
              end
            end
            default: begin
              // unused command: pass a through
              rnum  <= item.a_num;
              rden  <= item.a_den;
              state <= S_FIN;
            end
          endcase
        end
        S_RLOAD: begin
          d0    <= mag(wn);
          d1    <= mag(wd);
          u     <= mag(wn);
          v     <= mag(wd);
          k     <= '0;
          sn    <= wn[W-1];
          sd    <= wd[W-1];
          phase <= PH_RED;
          state <= S_GCD;
        end
        S_GCD: begin
          // binary GCD: one shift or one subtract per cycle
          if (u == '0) begin
            g     <= v << k;
            didx  <= 1'b0;
            state <= S_DLOAD;
          end else if (v == '0) begin
            g     <= u << k;
            didx  <= 1'b0;
            state <= S_DLOAD;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + CNT_W'(1);
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= u - v;
          end else begin
            v <= v - u;
          end
        end
        S_DLOAD: begin
          dq    <= didx ? d1 : d0;
          drem  <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dq   <= dq_next;
          drem <= drem_next;
          cnt  <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(W-1)) begin
            if (!didx) begin
              q0    <= dq_next;
              didx  <= 1'b1;
              state <= S_DLOAD;
            end else begin
              q1    <= dq_next;
              state <= S_POST;
            end
          end
        end
        S_POST: begin
          case (phase)
            PH_ADD: begin
              mstep <= 2'd0;
              state <= S_MUL;
            end
            PH_DIV: begin
              if (q1[W-1]) begin
                st    <= ST_OVF;
                state <= S_FIN;
              end else begin
                mb_n  <= q0_s;
                mb_d  <= q1;
                mstep <= 2'd0;
                state <= S_MUL;
              end
            end
            default: begin
              if (rovf) begin
                st <= ST_OVF;
              end
              rnum  <= rneg ? -$signed(q0) : $signed(q0);
              rden  <= $signed(q1);
              state <= S_FIN;
            end
          endcase
        end
        S_MUL: begin
          prod  <= opa * opb;
          state <= S_MCHK;
        end
        S_MCHK: begin
          if (!prod_fits) begin
            st    <= ST_OVF;
            state <= S_FIN;
          end else begin
            case (mstep)
              2'd0:    t0 <= prod[W-1:0];
              2'd1:    t1 <= prod[W-1:0];
              default: t2 <= prod[W-1:0];
            endcase
            if (last_step) begin
              state <= S_SUM;
            end else begin
              mstep <= mstep + 2'd1;
              state <= S_MUL;
            end
          end
        end
        S_SUM: begin
          if (is_add) begin
            if (sum[W] != sum[W-1]) begin
              st    <= ST_OVF;
              state <= S_FIN;
            end else begin
              wn    <= sum[W-1:0];
              wd    <= t0;
              state <= S_RLOAD;
            end
          end else begin
            wn    <= t0;
            wd    <= t1;
            state <= S_RLOAD;
          end
        end
        S_FIN: begin
          // hold here while the previous result is still waiting
          if (fin_load) begin
            res.res_num <= (st != ST_OK) ? item.a_num : rnum;
            res.res_den <= (st != ST_OK) ? item.a_den : rden;
            res.status  <= st;
            res_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> !op_ready)
    else $error("unit still ready after taking an item");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.status != 2'd3)
    else $error("undefined status code");

  a_error_returns_a: assert property (@(posedge clk) disable iff (rst)
    fin_load && st != ST_OK |=> res.res_num == item.a_num && res.res_den == item.a_den)
    else $error("error result is not operand a");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rau_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam int IDLE_LIMIT = 20000;

  logic     clk;
  logic     rst;
  logic     op_valid;
  logic     op_ready;
  rau_in_t  op;
  logic     res_valid;
  logic     res_ready;
  rau_out_t res;

  rational_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .op_valid(op_valid), .op_ready(op_ready), .op(op),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // Results still owed by the unit, oldest first.
  rau_out_t owed_results[$];
  int       errors;
  int       sent_count;
  int       got_count;
  int       idle_cycles;
  int       cmd_seen[8];
  int       st_seen[4];
  bit       hold_off;   // long receiver hold-off requested by a test
  bit       stall_on;   // random receiver stalls enabled

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Fraction arithmetic at 64-bit width, with overflow checks at 32 bits.
  // ---------------------------------------------------------------------
  function automatic bit in_word(input longint v);
    return v >= WMIN && v <= WMAX;
  endfunction

  function automatic longint abs64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint euclid(input longint x, input longint y);
    longint p;
    longint q;
    longint t;
    p = abs64(x);
    q = abs64(y);
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    return p;
  endfunction

  // Reduce n/d into rn/rd; return the status code.
  function automatic logic [1:0] lowest_terms(input longint n, input longint d,
                                              output longint rn, output longint rd);
    longint g;
    rn = 0;
    rd = 0;
    if (d == 0) return ST_DIV0;
    g = euclid(n, d);
    n = n / g;
    d = d / g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    if (!in_word(n) || !in_word(d)) return ST_OVF;
    rn = n;
    rd = d;
    return ST_OK;
  endfunction

  function automatic logic [1:0] frac_sum(input longint an, input longint ad,
                                          input longint bn, input longint bd,
                                          output longint rn, output longint rd);
    longint g;
    longint l;
    longint x;
    longint y;
    rn = 0;
    rd = 0;
    g = euclid(ad, bd);
    l = (ad / g) * bd;
    if (!in_word(l)) return ST_OVF;
    x = an * (l / ad);
    y = bn * (l / bd);
    if (!in_word(x) || !in_word(y)) return ST_OVF;
    if (!in_word(x + y)) return ST_OVF;
    return lowest_terms(x + y, l, rn, rd);
  endfunction

  function automatic logic [1:0] frac_product(input longint an, input longint ad,
                                              input longint bn, input longint bd,
                                              output longint rn, output longint rd);
    rn = 0;
    rd = 0;
    if (!in_word(an * bn) || !in_word(ad * bd)) return ST_OVF;
    return lowest_terms(an * bn, ad * bd, rn, rd);
  endfunction

  // Expected result of one command.
  function automatic rau_out_t rational_result(input rau_in_t it);
    longint an;
    longint ad;
    longint bn;
    longint bd;
    longint rn;
    longint rd;
    longint g;
    longint tn;
    longint td;
    logic [1:0] st;
    rau_out_t r;
    an = longint'(it.a_num);
    ad = longint'(it.a_den);
    bn = longint'(it.b_num);
    bd = longint'({1'b0, it.b_den});
    rn = an;
    rd = ad;
    st = ST_OK;
    if (it.cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV} && (ad == 0 || bd == 0)) begin
      st = ST_DIV0;
    end else begin
      case (it.cmd)
        CMD_NORM:  st = lowest_terms(an, ad, rn, rd);
        CMD_ADD:   st = frac_sum(an, ad, bn, bd, rn, rd);
        CMD_SUB: begin
          if (bn == WMIN) st = ST_OVF;
          else st = frac_sum(an, ad, -bn, bd, rn, rd);
        end
        CMD_MUL:   st = frac_product(an, ad, bn, bd, rn, rd);
        CMD_DIV: begin
          if (bn == 0) begin
            st = ST_DIV0;
          end else begin
            g = euclid(bd, bn);
            tn = bd / g;
            td = abs64(bn) / g;
            if (bn < 0) tn = -tn;
            if (!in_word(td)) st = ST_OVF;
            else st = frac_product(an, ad, tn, td, rn, rd);
          end
        end
        CMD_NEG: begin
          if (ad == 0) st = ST_DIV0;
          else if (an == WMIN) st = ST_OVF;
          else st = lowest_terms(-an, ad, rn, rd);
        end
        CMD_RECIP: begin
          if (an == 0) st = ST_DIV0;
          else st = lowest_terms(ad, an, rn, rd);
        end
        default: st = ST_OK;
      endcase
    end
    if (st != ST_OK) begin
      rn = an;
      rd = ad;
    end
    r.res_num = rn[31:0];
    r.res_den = rd[31:0];
    r.status  = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: drive at the falling edge, hold until accepted.
  // ---------------------------------------------------------------------
  task automatic send_item(input rau_in_t it);
    @(negedge clk);
    op       <= it;
    op_valid <= 1'b1;
    do @(posedge clk); while (!op_ready);
    owed_results = {owed_results, rational_result(it)};
    cmd_seen[it.cmd]++;
    sent_count++;
    @(negedge clk);
    op_valid <= 1'b0;
  endtask

  // Send a burst-shaped stream: occasional random gaps between items.
  task automatic pace_gap();
    int n;
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic rau_in_t make_item(input logic [2:0] c, input int an, input int ad,
                                        input int bn, input logic [30:0] bd);
    rau_in_t it;
    it.cmd   = c;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  // Random 32-bit value: mostly small, sometimes huge or extreme.
  function automatic int rand_word();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2:       return -int'($urandom_range(0, 1000));
      3:       return int'($urandom_range(0, 65535)) - 32768;
      default: return int'($urandom_range(0, 200)) - 100;
    endcase
  endfunction

  function automatic logic [30:0] rand_bden();
    case ($urandom_range(0, 7))
      0:       return 31'($urandom());
      1:       return 31'h7fffffff;
      2:       return 31'd0;
      default: return 31'($urandom_range(1, 300));
    endcase
  endfunction

  // Random item, mostly well-formed: a reduced with a positive denominator.
  function automatic rau_in_t rand_item();
    rau_in_t it;
    longint g;
    it.cmd   = 3'($urandom_range(0, 7));
    it.a_num = rand_word();
    it.a_den = rand_word();
    it.b_num = rand_word();
    it.b_den = rand_bden();
    if ($urandom_range(0, 4) != 0) begin
      // mostly valid operands so the arithmetic paths are exercised
      if (it.a_den <= 0) it.a_den = $urandom_range(1, 500);
      g = euclid(longint'(it.a_num), longint'(it.a_den));
      if (g > 1) begin
        it.a_num = int'(longint'(it.a_num) / g);
        it.a_den = int'(longint'(it.a_den) / g);
      end
      if (it.b_den == 0) it.b_den = 31'($urandom_range(1, 500));
      g = euclid(longint'(it.b_num), longint'({1'b0, it.b_den}));
      if (g > 1) begin
        it.b_num = int'(longint'(it.b_num) / g);
        it.b_den = 31'(longint'({1'b0, it.b_den}) / g);
      end
    end
    return it;
  endfunction

  task automatic wait_drained();
    while (owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    send_item(make_item(CMD_NORM, 6, -4, 0, 31'd1));
    send_item(make_item(CMD_NORM, 5, 0, 0, 31'd1));
    send_item(make_item(CMD_NORM, 32'h80000000, -1, 0, 31'd1));
    send_item(make_item(CMD_NORM, 1, 32'h80000000, 0, 31'd1));
    send_item(make_item(CMD_ADD, 1, 2, 1, 31'd3));
    send_item(make_item(CMD_ADD, 1, 0, 1, 31'd3));
    send_item(make_item(CMD_ADD, 1, 2, 1, 31'd0));
    send_item(make_item(CMD_ADD, 32'h7fffffff, 1, 1, 31'd1));
    send_item(make_item(CMD_ADD, 1, 32'h7fffffff, 1, 31'h7ffffffe));
    send_item(make_item(CMD_SUB, 3, 4, 32'h80000000, 31'd1));
    send_item(make_item(CMD_SUB, 3, 4, 0, 31'd1));
    send_item(make_item(CMD_SUB, 32'h80000000, 1, 1, 31'd1));
    send_item(make_item(CMD_MUL, 2, 3, -3, 31'd4));
    send_item(make_item(CMD_MUL, 32'h10000, 1, 32'h10000, 31'd1));
    send_item(make_item(CMD_DIV, 2, 3, 0, 31'd1));
    send_item(make_item(CMD_DIV, 2, 3, -4, 31'd5));
    send_item(make_item(CMD_DIV, 1, 1, 32'h80000000, 31'd1));
    send_item(make_item(CMD_NEG, 0, 7, 0, 31'd1));
    send_item(make_item(CMD_NEG, 32'h80000000, 1, 0, 31'd1));
    send_item(make_item(CMD_NEG, 3, 0, 0, 31'd1));
    send_item(make_item(CMD_RECIP, 0, 5, 0, 31'd1));
    send_item(make_item(CMD_RECIP, 7, 0, 0, 31'd1));
    send_item(make_item(CMD_RECIP, -3, 9, 0, 31'd1));
    send_item(make_item(3'd7, -1, -1, -1, 31'h7fffffff));
    wait_drained();
  endtask

  task automatic test_random(input int count);
    repeat (count) begin
      send_item(rand_item());
      pace_gap();
    end
    wait_drained();
  endtask

  // Hold the receiver off while items keep coming, so the unit backs up.
  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (6) send_item(rand_item());
    hold_off = 1'b0;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Receiver stalls: a pattern of its own, plus the long hold-off.
  // ---------------------------------------------------------------------
  initial begin
    int hold_cnt;
    res_ready = 1'b0;
    hold_cnt  = 0;
    forever begin
      @(negedge clk);
      if (hold_off && hold_cnt < 600) begin
        hold_cnt++;
        res_ready <= 1'b0;
      end else begin
        if (!hold_off) hold_cnt = 0;
        res_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  // Check each accepted result against the oldest owed result.
  always @(posedge clk) begin
    rau_out_t want;
    if (!rst && res_valid && res_ready) begin
      got_count <= got_count + 1;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d status=%0d",
                 $time, res.res_num, res.res_den, res.status);
        errors++;
      end else begin
        want = owed_results.pop_front();
        st_seen[res.status]++;
        if (res.res_num !== want.res_num) begin
          $display("%0t: res_num expected %0d actual %0d", $time, want.res_num,
                   res.res_num);
          errors++;
        end
        if (res.res_den !== want.res_den) begin
          $display("%0t: res_den expected %0d actual %0d", $time, want.res_den,
                   res.res_den);
          errors++;
        end
        if (res.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   res.status);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (op_valid && op_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    op_valid    = 1'b0;
    op          = '0;
    errors      = 0;
    sent_count  = 0;
    got_count   = 0;
    idle_cycles = 0;
    hold_off    = 1'b0;
    stall_on    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    stall_on = 1'b1;
    test_backpressure();
    test_random(350);
    stall_on = 1'b0;
    test_random(150);
    stall_on = 1'b1;
    test_random(200);
    repeat (20) @(posedge clk);

    $display("run covered %0d items, %0d results; cmds 0-7: %0d %0d %0d %0d %0d %0d %0d %0d",
             sent_count, got_count, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3],
             cmd_seen[4], cmd_seen[5], cmd_seen[6], cmd_seen[7]);
    $display("statuses ok/overflow/div-by-zero: %0d %0d %0d", st_seen[0], st_seen[1],
             st_seen[2]);
    if (errors == 0 && owed_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
